// File: rtl/core/bmsi_pkg.sv
// Package for the bank mapper with scanline IRQ.
// Holds the command codes, the register decode values and the mapper constants.
// No dependencies.
`default_nettype none

package bmsi_pkg;

  // Command codes carried by each input item.
  localparam logic [2:0] CmdRegWrite = 3'd0;
  localparam logic [2:0] CmdPrgXlate = 3'd1;
  localparam logic [2:0] CmdChrXlate = 3'd2;
  localparam logic [2:0] CmdNtXlate  = 3'd3;
  localparam logic [2:0] CmdPpuTick  = 3'd4;

  // CPU register decode, taken from address & RegDecodeMask.
  localparam logic [15:0] RegDecodeMask = 16'hE003;
  localparam logic [15:0] RegPrg0       = 16'h8000;
  localparam logic [15:0] RegPrg1       = 16'h8001;
  localparam logic [15:0] RegChr2k0     = 16'h8002;
  localparam logic [15:0] RegChr2k1     = 16'h8003;
  localparam logic [15:0] RegChr1k0     = 16'hA000;
  localparam logic [15:0] RegChr1k1     = 16'hA001;
  localparam logic [15:0] RegChr1k2     = 16'hA002;
  localparam logic [15:0] RegChr1k3     = 16'hA003;
  localparam logic [15:0] RegIrqLatch   = 16'hC000;
  localparam logic [15:0] RegIrqReload  = 16'hC001;
  localparam logic [15:0] RegIrqEnable  = 16'hC002;
  localparam logic [15:0] RegIrqDisable = 16'hC003;
  localparam logic [15:0] RegMirror     = 16'hE000;

  // Configuration register indexes.
  localparam logic CfgChipRevision = 1'b0;
  localparam logic CfgSepMirror    = 1'b1;

  // Fixed program banks for the upper two 8K windows.
  localparam logic [5:0] PrgFixedLow  = 6'h3E;
  localparam logic [5:0] PrgFixedHigh = 6'h3F;

  localparam logic [7:0] IrqCountTop  = 8'hFF;
  localparam logic [2:0] HoldoffTicks = 3'd6;

  localparam int unsigned MappedWidth = 19;
  localparam int unsigned ChrBanks    = 6;

endpackage

`default_nettype wire

// File: rtl/core/bank_mapper_with_scanline_irq.sv
// Top level of the bank mapper with scanline IRQ: register decode, address
// translation and the A12 scanline counter. Depends on bmsi_pkg.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    command_i, address_i, data_i
// out       output     out_valid_o / out_ready_i  mapped_address_o, irq_line_o
// apb       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Every item is decoded and applied in the cycle it is accepted; its result
// is registered as it is accepted, so one item per cycle is sustained unless stalled.
// The single output register is the only buffer: a new item is taken whenever
// the register is empty or its result is taken in the same cycle.
// A stall on the output side holds in_ready_o low until the result is taken.
// Reset clears all mapper state, the configuration and the output valid flag.

module bank_mapper_with_scanline_irq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [18:0]      mapped_address_o,
  output logic             irq_line_o,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic [1:0] chip_rev_q;
  logic       sep_mirror_q;

  // Mapper state.
  logic [5:0] prg_bank_q [2];
  logic [7:0] chr_bank_q [bmsi_pkg::ChrBanks];
  logic       mirror_q,  mirror_d;
  logic [7:0] reload_q,  reload_d;
  logic [7:0] count_q,   count_d;
  logic       armed_q,   armed_d;
  logic [2:0] holdoff_q, holdoff_d;
  logic       irq_q,     irq_d;
  logic       a12_q,     a12_d;

  logic       prg_we;
  logic       prg_sel;
  logic       chr_we;
  logic [2:0] chr_sel;

  logic [18:0] mapped_d;
  logic        accept;
  logic        cfg_we;
  logic        irq_capable;
  logic        mirror_e000;
  logic [15:0] reg_addr;
  logic [2:0]  hold_dec;
  logic        a12_fall;
  logic [7:0]  count_inc;
  logic [5:0]  prg_bank;
  logic [12:0] chr_addr;

  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite && pready;

  // Revision three is treated like revision two through bit 1 alone.
  assign irq_capable = (chip_rev_q != 2'd0);
  assign mirror_e000 = chip_rev_q[1] || sep_mirror_q;

  assign reg_addr  = address_i & bmsi_pkg::RegDecodeMask;
  assign hold_dec  = (holdoff_q != 3'd0) ? holdoff_q - 3'd1 : 3'd0;
  assign a12_fall  = a12_q && !address_i[12];
  assign count_inc = count_q + 8'd1;
  assign chr_addr  = address_i[12:0];

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[2])
      bmsi_pkg::CfgChipRevision: prdata = {30'd0, chip_rev_q};
      bmsi_pkg::CfgSepMirror:    prdata = {31'd0, sep_mirror_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // Register write decode and tick sequencing.
  always_comb begin
    mirror_d  = mirror_q;
    reload_d  = reload_q;
    count_d   = count_q;
    armed_d   = armed_q;
    holdoff_d = holdoff_q;
    irq_d     = irq_q;
    a12_d     = a12_q;
    prg_we    = 1'b0;
    prg_sel   = 1'b0;
    chr_we    = 1'b0;
    chr_sel   = 3'd0;
    if (accept && command_i == bmsi_pkg::CmdRegWrite) begin
      unique case (reg_addr)
        bmsi_pkg::RegPrg0: begin
          prg_we = 1'b1;
          if (!mirror_e000) begin
            mirror_d = data_i[6];
          end
        end
        bmsi_pkg::RegPrg1: begin
          prg_we  = 1'b1;
          prg_sel = 1'b1;
        end
        bmsi_pkg::RegChr2k0: begin chr_we = 1'b1; chr_sel = 3'd0; end
        bmsi_pkg::RegChr2k1: begin chr_we = 1'b1; chr_sel = 3'd1; end
        bmsi_pkg::RegChr1k0: begin chr_we = 1'b1; chr_sel = 3'd2; end
        bmsi_pkg::RegChr1k1: begin chr_we = 1'b1; chr_sel = 3'd3; end
        bmsi_pkg::RegChr1k2: begin chr_we = 1'b1; chr_sel = 3'd4; end
        bmsi_pkg::RegChr1k3: begin chr_we = 1'b1; chr_sel = 3'd5; end
        bmsi_pkg::RegIrqLatch: begin
          if (irq_capable) reload_d = data_i;
        end
        bmsi_pkg::RegIrqReload: begin
          if (irq_capable) count_d = bmsi_pkg::IrqCountTop;
        end
        bmsi_pkg::RegIrqEnable: begin
          if (irq_capable) armed_d = 1'b1;
        end
        bmsi_pkg::RegIrqDisable: begin
          if (irq_capable) begin
            armed_d = 1'b0;
            irq_d   = 1'b0;
          end
        end
        bmsi_pkg::RegMirror: begin
          if (mirror_e000) mirror_d = data_i[6];
        end
        default: ;
      endcase
    end else if (accept && command_i == bmsi_pkg::CmdPpuTick && irq_capable) begin
      holdoff_d = hold_dec;
      if (a12_fall) begin
        // The counter only moves once the holdoff from the last edge has run out.
        if (hold_dec == 3'd0) begin
          if (count_q == bmsi_pkg::IrqCountTop) begin
            count_d = reload_q;
          end else begin
            count_d = count_inc;
            if (count_inc == bmsi_pkg::IrqCountTop && armed_q) irq_d = 1'b1;
          end
        end
        holdoff_d = bmsi_pkg::HoldoffTicks;
      end
      a12_d = address_i[12];
    end
  end

  // Address translation from the state as it stands before the item.
  always_comb begin
    unique case (address_i[14:13])
      2'd0:    prg_bank = prg_bank_q[0];
      2'd1:    prg_bank = prg_bank_q[1];
      2'd2:    prg_bank = bmsi_pkg::PrgFixedLow;
      default: prg_bank = bmsi_pkg::PrgFixedHigh;
    endcase
  end

  always_comb begin
    mapped_d = '0;
    unique case (command_i)
      bmsi_pkg::CmdPrgXlate: mapped_d = {prg_bank, address_i[12:0]};
      bmsi_pkg::CmdChrXlate: begin
        if (!chr_addr[12]) begin
          mapped_d = {chr_bank_q[{2'd0, chr_addr[11]}], chr_addr[10:0]};
        end else begin
          mapped_d = {1'b0, chr_bank_q[3'd2 + {1'b0, chr_addr[11:10]}], chr_addr[9:0]};
        end
      end
      bmsi_pkg::CmdNtXlate: begin
        // Vertical mirroring keeps A10, horizontal moves A11 down to A10.
        mapped_d = {8'd0, mirror_q ? address_i[11] : address_i[10], address_i[9:0]};
      end
      default: mapped_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_rev_q   <= 2'd0;
      sep_mirror_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        bmsi_pkg::CfgChipRevision: chip_rev_q   <= pwdata[1:0];
        bmsi_pkg::CfgSepMirror:    sep_mirror_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bank_q[0] <= '0;
      prg_bank_q[1] <= '0;
      for (int i = 0; i < bmsi_pkg::ChrBanks; i++) begin
        chr_bank_q[i] <= '0;
      end
      mirror_q  <= 1'b0;
      reload_q  <= '0;
      count_q   <= '0;
      armed_q   <= 1'b0;
      holdoff_q <= '0;
      irq_q     <= 1'b0;
      a12_q     <= 1'b0;
    end else begin
      if (prg_we) prg_bank_q[prg_sel] <= data_i[5:0];
      if (chr_we) chr_bank_q[chr_sel] <= data_i;
      mirror_q  <= mirror_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
      armed_q   <= armed_d;
      holdoff_q <= holdoff_d;
      irq_q     <= irq_d;
      a12_q     <= a12_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_o <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mapped_address_o <= mapped_d;
      irq_line_o       <= irq_d;
    end
  end

  // The IRQ line only ever rises on a PPU tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_q) |-> $past(accept && command_i == bmsi_pkg::CmdPpuTick))
    else $error("irq rose without a ppu tick");

  // The holdoff never exceeds its reload value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    holdoff_q <= bmsi_pkg::HoldoffTicks)
    else $error("holdoff out of range");

  // A revision without IRQ support leaves the counter alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chip_rev_q == 2'd0) |=> $stable(count_q))
    else $error("irq counter moved on a non-irq revision");

  // A waiting result shows the current IRQ level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (irq_line_o == irq_q))
    else $error("irq_line_o out of step with irq state");

endmodule

`default_nettype wire
